// File: src/xhl_pkg.sv
`default_nettype none
package xhl_pkg;

   localparam int HOLD_DEPTH  = 5;
   localparam int MAX_RESULTS = 6;
   localparam int NUM_OPENERS = 4;

   // lexer modes
   localparam logic [2:0] MODE_TEXT       = 3'd0;
   localparam logic [2:0] MODE_COMMENT    = 3'd1;
   localparam logic [2:0] MODE_TAG        = 3'd2;
   localparam logic [2:0] MODE_XML_TAG    = 3'd3;
   localparam logic [2:0] MODE_XSL_TAG    = 3'd4;
   localparam logic [2:0] MODE_STRING     = 3'd5;
   localparam logic [2:0] MODE_XML_STRING = 3'd6;
   localparam logic [2:0] MODE_XSL_STRING = 3'd7;
   // string modes sit this far above their tag modes
   localparam logic [2:0] STRING_OFFSET   = 3'd3;

   // highlight classes
   localparam logic [2:0] CLS_PLAIN   = 3'd0;
   localparam logic [2:0] CLS_COMMENT = 3'd1;
   localparam logic [2:0] CLS_TAG     = 3'd2;
   localparam logic [2:0] CLS_XML_TAG = 3'd3;
   localparam logic [2:0] CLS_XSL_TAG = 3'd4;
   localparam logic [2:0] CLS_STRING  = 3'd5;

   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;

   // text after '<': "!--", "?xml", "xsl:", "/xsl:"
   localparam logic [7:0] OPENER_TXT [NUM_OPENERS][HOLD_DEPTH] = '{
      '{8'h21, 8'h2D, 8'h2D, 8'h00, 8'h00},
      '{8'h3F, 8'h78, 8'h6D, 8'h6C, 8'h00},
      '{8'h78, 8'h73, 8'h6C, 8'h3A, 8'h00},
      '{8'h2F, 8'h78, 8'h73, 8'h6C, 8'h3A}
   };
   localparam logic [2:0] OPENER_LEN [NUM_OPENERS] = '{3'd3, 3'd4, 3'd4, 3'd5};
   localparam logic [2:0] OPENER_CLS [NUM_OPENERS] =
      '{CLS_COMMENT, CLS_XML_TAG, CLS_XSL_TAG, CLS_XSL_TAG};

   // all results caused by one item
   typedef struct packed {
      logic [2:0]                        count;
      logic [MAX_RESULTS-1:0][7:0]       chars;
      logic [MAX_RESULTS-1:0][2:0]       classes;
   } res_bundle_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage
`default_nettype wire

// File: src/xhl_channels.sv
`default_nettype none
interface xhl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       line_end;

   modport source (output valid, output char_in, output line_end, input ready);
   modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface xhl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic [2:0] char_class;
   logic       last_of_run;

   modport source (output valid, output char_out, output char_class, output last_of_run,
                   input ready);
   modport sink   (input valid, input char_out, input char_class, input last_of_run,
                   output ready);
endinterface
`default_nettype wire

// File: src/xhl_front.sv
`default_nettype none
module xhl_front (
   input  logic                      clock,
   input  logic                      reset,
   xhl_req_if.sink                   req,
   input  xhl_pkg::queue_status_type status,
   output logic                      push,
   output xhl_pkg::res_bundle_type   bundle
);
   import xhl_pkg::*;

   logic [2:0] mode_ff, mode_in;
   logic [7:0] held_ff [HOLD_DEPTH];
   logic [7:0] held_in [HOLD_DEPTH];
   logic [2:0] held_cnt_ff, held_cnt_in;
   logic [1:0] dash_ff, dash_in;
   logic       guard_ff, guard_in;

   logic       accept;
   logic [7:0] c;
   logic       eol;

   assign accept    = req.valid && req.ready;
   assign req.ready = !status.full;
   assign c         = req.char_in;
   assign eol       = req.line_end;

   always_comb begin
      logic [7:0] t [HOLD_DEPTH];
      logic       full_hit;
      logic [2:0] full_cls;
      logic       prefix;
      logic       same;
      logic       run_lex;
      logic [2:0] lmode;
      logic [2:0] n;

      bundle      = '0;
      n           = 3'd0;
      mode_in     = mode_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      dash_in     = dash_ff;
      guard_in    = guard_ff;
      run_lex     = 1'b0;
      lmode       = mode_ff;

      // candidate opener text: held bytes after '<', then the new byte
      for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
         t[i] = (3'(i + 1) < held_cnt_ff) ? held_ff[i + 1] : c;
      end
      t[HOLD_DEPTH-1] = c;

      full_hit = 1'b0;
      full_cls = CLS_TAG;
      prefix   = 1'b0;
      for (int k = 0; k < NUM_OPENERS; k++) begin
         same = OPENER_LEN[k] >= held_cnt_ff;
         for (int i = 0; i < HOLD_DEPTH; i++) begin
            if (3'(i) < held_cnt_ff && t[i] != OPENER_TXT[k][i]) begin
               same = 1'b0;
            end
         end
         if (same) begin
            if (OPENER_LEN[k] == held_cnt_ff) begin
               full_hit = 1'b1;
               full_cls = OPENER_CLS[k];
            end else begin
               prefix = 1'b1;
            end
         end
      end

      if (held_cnt_ff != 3'd0 && mode_ff == MODE_TEXT) begin
         if (full_hit) begin
            if (full_cls == CLS_COMMENT) begin
               // dashes of the opener stay held as comment dashes
               bundle.chars[0]   = CH_LT;
               bundle.classes[0] = CLS_COMMENT;
               bundle.chars[1]   = CH_BANG;
               bundle.classes[1] = CLS_COMMENT;
               n       = 3'd2;
               dash_in = 2'd2;
            end else begin
               for (int i = 0; i < HOLD_DEPTH; i++) begin
                  if (3'(i) < held_cnt_ff) begin
                     bundle.chars[i]   = held_ff[i];
                     bundle.classes[i] = full_cls;
                  end
               end
               n = held_cnt_ff;
               bundle.chars[n]   = c;
               bundle.classes[n] = full_cls;
               n = n + 3'd1;
            end
            mode_in     = full_cls;
            held_cnt_in = 3'd0;
         end else if (prefix && !eol && held_cnt_ff < 3'(HOLD_DEPTH)) begin
            held_in[held_cnt_ff] = c;
            held_cnt_in          = held_cnt_ff + 3'd1;
         end else begin
            // mismatch: held bytes become a plain tag, byte lexed as tag
            for (int i = 0; i < HOLD_DEPTH; i++) begin
               if (3'(i) < held_cnt_ff) begin
                  bundle.chars[i]   = held_ff[i];
                  bundle.classes[i] = CLS_TAG;
               end
            end
            n           = held_cnt_ff;
            held_cnt_in = 3'd0;
            mode_in     = MODE_TAG;
            lmode       = MODE_TAG;
            run_lex     = 1'b1;
         end
      end else begin
         held_cnt_in = 3'd0;
         run_lex     = 1'b1;
      end

      if (run_lex) begin
         unique case (lmode) inside
            MODE_TEXT: begin
               if (c == CH_LT) begin
                  if (eol) begin
                     bundle.chars[n]   = c;
                     bundle.classes[n] = CLS_TAG;
                     n       = n + 3'd1;
                     mode_in = MODE_TAG;
                  end else begin
                     held_in[0]  = c;
                     held_cnt_in = 3'd1;
                  end
               end else begin
                  bundle.chars[n]   = c;
                  bundle.classes[n] = CLS_PLAIN;
                  n = n + 3'd1;
               end
            end
            MODE_COMMENT: begin
               if (c == CH_DASH) begin
                  if (dash_ff < 2'd2) begin
                     dash_in = dash_ff + 2'd1;
                  end else begin
                     bundle.chars[n]   = CH_DASH;
                     bundle.classes[n] = CLS_COMMENT;
                     n = n + 3'd1;
                  end
               end else if (c == CH_GT && dash_ff == 2'd2) begin
                  // closing "-->" is plain
                  bundle.chars[n]   = CH_DASH;
                  bundle.classes[n] = CLS_PLAIN;
                  n = n + 3'd1;
                  bundle.chars[n]   = CH_DASH;
                  bundle.classes[n] = CLS_PLAIN;
                  n = n + 3'd1;
                  bundle.chars[n]   = c;
                  bundle.classes[n] = CLS_PLAIN;
                  n = n + 3'd1;
                  dash_in = 2'd0;
                  mode_in = MODE_TEXT;
               end else begin
                  for (int i = 0; i < 2; i++) begin
                     if (2'(i) < dash_ff) begin
                        bundle.chars[n]   = CH_DASH;
                        bundle.classes[n] = CLS_COMMENT;
                        n = n + 3'd1;
                     end
                  end
                  dash_in = 2'd0;
                  bundle.chars[n]   = c;
                  bundle.classes[n] = CLS_COMMENT;
                  n = n + 3'd1;
               end
            end
            MODE_TAG, MODE_XML_TAG, MODE_XSL_TAG: begin
               bundle.chars[n] = c;
               if (c == CH_GT) begin
                  bundle.classes[n] = lmode;
                  mode_in = MODE_TEXT;
               end else if (c == CH_QUOTE) begin
                  bundle.classes[n] = CLS_STRING;
                  mode_in = lmode + STRING_OFFSET;
               end else begin
                  bundle.classes[n] = lmode;
               end
               n = n + 3'd1;
            end
            default: begin
               // string modes
               bundle.chars[n]   = c;
               bundle.classes[n] = CLS_STRING;
               n = n + 3'd1;
               if (c == CH_QUOTE && !guard_ff) begin
                  mode_in = lmode - STRING_OFFSET;
               end
            end
         endcase
      end

      if (eol) begin
         if (mode_in == MODE_COMMENT) begin
            for (int i = 0; i < 2; i++) begin
               if (2'(i) < dash_in) begin
                  bundle.chars[n]   = CH_DASH;
                  bundle.classes[n] = CLS_COMMENT;
                  n = n + 3'd1;
               end
            end
         end
         dash_in     = 2'd0;
         held_cnt_in = 3'd0;
         guard_in    = mode_in >= MODE_STRING;
      end else begin
         guard_in = 1'b0;
      end

      bundle.count = n;
   end

   assign push = accept && bundle.count != 3'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_TEXT;
         held_cnt_ff <= 3'd0;
         dash_ff     <= 2'd0;
         guard_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         held_cnt_ff <= held_cnt_in;
         dash_ff     <= dash_in;
         guard_ff    <= guard_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   a_hold_only_text: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_TEXT |-> held_cnt_ff == 3'd0)
      else $error("bytes held outside text mode");
   a_dash_only_comment: assert property (@(posedge clock) disable iff (reset)
      dash_ff != 2'd0 |-> mode_ff == MODE_COMMENT)
      else $error("dashes held outside comment mode");
   a_hold_depth: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff <= 3'(HOLD_DEPTH))
      else $error("held count beyond depth");

endmodule
`default_nettype wire

// File: src/xhl_queue.sv
`default_nettype none
module xhl_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  xhl_pkg::res_bundle_type   push_data,
   input  logic                      pop,
   output xhl_pkg::res_bundle_type   head,
   output xhl_pkg::queue_status_type status
);
   import xhl_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   res_bundle_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign status.empty = count_ff == '0;
   assign status.full  = count_ff == CNT_W'(DEPTH);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule
`default_nettype wire

// File: src/xhl_back.sv
`default_nettype none
module xhl_back (
   input  logic                      clock,
   input  logic                      reset,
   input  xhl_pkg::res_bundle_type   head,
   input  xhl_pkg::queue_status_type status,
   output logic                      pop,
   xhl_rsp_if.source                 rsp
);
   import xhl_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       last;
   logic       take;

   assign last            = idx_ff == head.count - 3'd1;
   assign take            = rsp.valid && rsp.ready;
   assign pop             = take && last;
   assign rsp.valid       = !status.empty;
   assign rsp.char_out    = head.chars[idx_ff];
   assign rsp.char_class  = head.classes[idx_ff];
   assign rsp.last_of_run = last;

   always_comb begin
      idx_in = idx_ff;
      if (take) begin
         idx_in = last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      !status.empty |-> idx_ff < head.count)
      else $error("result index past bundle count");

endmodule
`default_nettype wire

// File: src/xml_highlight_lexer_top.sv
`default_nettype none
// Channel   Dir  Payload                                  Notes
// req_chan  in   char_in[7:0], line_end                   one text byte per item
// rsp_chan  out  char_out[7:0], char_class[2:0],          one classified byte per item,
//                last_of_run                              last_of_run closes an input's run
//
// Each input item is classified as it is accepted; its 0 to 6 results are written
// as one bundle into a QUEUE_DEPTH-entry queue and leave one per cycle while rsp is ready.
// A result can appear the cycle after its input is accepted.
// req_chan.ready drops only while the bundle queue is full; rsp stalls fill it.
// Reset (synchronous) returns the lexer to text mode and empties the queue.
module xml_highlight_lexer_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   xhl_req_if.sink   req_chan,
   xhl_rsp_if.source rsp_chan
);
   import xhl_pkg::*;

   // classifier -> queue
   logic             push;
   res_bundle_type   push_data;
   // queue -> serializer
   res_bundle_type   head;
   queue_status_type status;
   logic             pop;

   // front: holds opener and comment-dash bytes, emits a result bundle per item with results
   xhl_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .status (status),
      .push   (push),
      .bundle (push_data)
   );

   // bundle queue decoupling front from back
   xhl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (status)
   );

   // back: walks the head bundle one result per cycle while rsp_chan is ready
   xhl_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .status (status),
      .pop    (pop),
      .rsp    (rsp_chan)
   );

endmodule
`default_nettype wire
